### rtl/core/whitespace_collapse_utf16_encoder_top_macros.svh
// Assertion helpers shared by the RTL.
`ifndef WHITESPACE_COLLAPSE_UTF16_ENCODER_TOP_MACROS_SVH
`define WHITESPACE_COLLAPSE_UTF16_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/wsc_u16_pkg.sv
package wsc_u16_pkg;

  typedef enum logic [1:0] {
    OP_CODE_POINT  = 2'd0,
    OP_LINE_BREAK  = 2'd1,
    OP_FLUSH       = 2'd2,
    OP_BLOCK_START = 2'd3
  } op_e;

  localparam int unsigned MaxUnits = 3;

  localparam logic [15:0] UnitSpace = 16'h0020;
  localparam logic [15:0] UnitLf    = 16'h000A;
  localparam logic [20:0] CpSpace   = 21'h000020;
  localparam logic [20:0] CpTab     = 21'h000009;
  localparam logic [20:0] CpCr      = 21'h00000D;
  localparam logic [20:0] CpLf      = 21'h00000A;
  localparam logic [20:0] AstralBase = 21'h010000;
  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;

  // Units produced by one accepted item, handed to the output buffer
  typedef struct packed {
    logic                          load;
    logic [1:0]                    count;
    logic [MaxUnits-1:0][15:0]     unit;
    logic [MaxUnits-1:0][31:0]     offset;
  } res_t;

endpackage

### rtl/core/wsc_u16_in_if.sv
interface wsc_u16_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [20:0] code_point;
  logic [31:0] char_offset;

  modport source (output valid, output operation, output code_point, output char_offset,
                  input ready);
  modport sink (input valid, input operation, input code_point, input char_offset,
                output ready);
endinterface

### rtl/core/wsc_u16_out_if.sv
interface wsc_u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] utf16_unit;
  logic [31:0] source_offset;
  logic        last_of_run;

  modport source (output valid, output utf16_unit, output source_offset,
                  output last_of_run, input ready);
  modport sink (input valid, input utf16_unit, input source_offset,
                input last_of_run, output ready);
endinterface

### rtl/core/wsc_u16_cfg_if.sv
interface wsc_u16_cfg_if;
  logic valid;
  logic ready;
  logic preformatted_mode;

  modport source (output valid, output preformatted_mode, input ready);
  modport sink (input valid, input preformatted_mode, output ready);
endinterface

### rtl/core/wsc_u16_encoder.sv
module wsc_u16_encoder
  import wsc_u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  wsc_u16_in_if.sink       in_i,
  wsc_u16_cfg_if.sink      cfg_i,
  input  logic             in_ready_i,
  output res_t             res_o
);

  logic        pre_mode_q;
  logic        pending_q, pending_d;
  logic [31:0] pending_pos_q, pending_pos_d;
  logic [15:0] last_unit_q, last_unit_d;
  logic        empty_q, empty_d;

  op_e         op;
  logic        in_fire;
  logic        is_ws;
  logic        collapse;
  logic        do_flush;
  logic        emit_space;
  logic        astral;
  logic [20:0] rest;
  logic [15:0] surr_hi;
  logic [15:0] surr_lo;
  logic [1:0]  k;
  logic [15:0] final_unit;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready_i;
  assign in_fire     = in_i.valid && in_ready_i;

  assign op    = op_e'(in_i.operation);
  assign is_ws = (in_i.code_point == CpSpace) || (in_i.code_point == CpTab) ||
                 (in_i.code_point == CpCr) || (in_i.code_point == CpLf);
  assign collapse = (op == OP_CODE_POINT) && !pre_mode_q && is_ws;
  assign do_flush = (op != OP_BLOCK_START) && !collapse;
  assign emit_space = do_flush && pending_q && !empty_q &&
                      (last_unit_q != UnitSpace) && (last_unit_q != UnitLf);

  assign astral  = (in_i.code_point[20:16] != 5'd0);
  assign rest    = in_i.code_point - AstralBase;
  assign surr_hi = SurrHiBase + {5'd0, rest[20:10]};
  assign surr_lo = SurrLoBase + {6'd0, rest[9:0]};

  // Pack the units of this transaction in emission order
  always_comb begin
    res_o        = '0;
    k            = 2'd0;
    final_unit   = UnitSpace;
    res_o.offset = {MaxUnits{in_i.char_offset}};
    if (emit_space) begin
      res_o.unit[0]   = UnitSpace;
      res_o.offset[0] = pending_pos_q;
      k               = 2'd1;
    end
    unique case (op)
      OP_CODE_POINT: begin
        if (!collapse) begin
          if (astral) begin
            res_o.unit[k]        = surr_hi;
            res_o.unit[k + 2'd1] = surr_lo;
            final_unit           = surr_lo;
            k                    = k + 2'd2;
          end else begin
            res_o.unit[k] = in_i.code_point[15:0];
            final_unit    = in_i.code_point[15:0];
            k             = k + 2'd1;
          end
        end
      end
      OP_LINE_BREAK: begin
        res_o.unit[k] = UnitLf;
        final_unit    = UnitLf;
        k             = k + 2'd1;
      end
      OP_FLUSH, OP_BLOCK_START: begin
      end
      default: begin
      end
    endcase
    res_o.count = k;
    res_o.load  = in_fire && (k != 2'd0);
  end

  always_comb begin
    pending_d     = pending_q;
    pending_pos_d = pending_pos_q;
    last_unit_d   = last_unit_q;
    empty_d       = empty_q;
    if (op == OP_BLOCK_START) begin
      pending_d   = 1'b0;
      empty_d     = 1'b1;
      last_unit_d = 16'h0000;
    end else if (collapse) begin
      // keep the position of the first whitespace of the run
      if (!pending_q) begin
        pending_d     = 1'b1;
        pending_pos_d = in_i.char_offset;
      end
    end else begin
      pending_d = 1'b0;
      if (k != 2'd0) begin
        last_unit_d = final_unit;
        empty_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_mode_q    <= 1'b0;
      pending_q     <= 1'b0;
      pending_pos_q <= 32'd0;
      last_unit_q   <= 16'd0;
      empty_q       <= 1'b1;
    end else begin
      if (cfg_i.valid) begin
        pre_mode_q <= cfg_i.preformatted_mode;
      end
      if (in_fire) begin
        pending_q     <= pending_d;
        pending_pos_q <= pending_pos_d;
        last_unit_q   <= last_unit_d;
        empty_q       <= empty_d;
      end
    end
  end

endmodule

### rtl/core/wsc_u16_outbuf.sv
module wsc_u16_outbuf
  import wsc_u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  res_t             res_i,
  output logic             in_ready_o,
  wsc_u16_out_if.source    out_o
);

  logic [1:0]                n_q, n_d;
  logic [1:0]                rd_q, rd_d;
  logic [MaxUnits-1:0][15:0] unit_q;
  logic [MaxUnits-1:0][31:0] offset_q;
  logic                      last;
  logic                      out_fire;

  assign last     = (rd_q == (n_q - 2'd1));
  assign out_fire = out_o.valid && out_o.ready;

  assign out_o.valid         = (n_q != 2'd0);
  assign out_o.utf16_unit    = unit_q[rd_q];
  assign out_o.source_offset = offset_q[rd_q];
  assign out_o.last_of_run   = last;

  // Take a new transaction once the final unit held here leaves
  assign in_ready_o = (n_q == 2'd0) || (out_o.ready && last);

  always_comb begin
    n_d  = n_q;
    rd_d = rd_q;
    if (out_fire) begin
      if (last) begin
        n_d  = 2'd0;
        rd_d = 2'd0;
      end else begin
        rd_d = rd_q + 2'd1;
      end
    end
    if (res_i.load) begin
      n_d  = res_i.count;
      rd_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q  <= 2'd0;
      rd_q <= 2'd0;
    end else begin
      n_q  <= n_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      unit_q   <= res_i.unit;
      offset_q <= res_i.offset;
    end
  end

endmodule

### rtl/core/whitespace_collapse_utf16_encoder_top.sv
// Channel | Dir | Payload                                    | Transfer
// in_i    | in  | operation, code_point, char_offset         | valid && ready
// cfg_i   | in  | preformatted_mode                          | valid && ready
// out_o   | out | utf16_unit, source_offset, last_of_run     | valid && ready
//
// An item that yields no unit loads nothing; the units of an item leave the
// output register one unit per cycle while out_o.ready is high.
// The output register holds up to three units; the next item is taken in the
// cycle its last unit leaves. Reset is asynchronous, active low; it clears
// control state and the whitespace state. cfg_i is always ready.
`include "whitespace_collapse_utf16_encoder_top_macros.svh"

module whitespace_collapse_utf16_encoder_top
  import wsc_u16_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  wsc_u16_in_if.sink    in_i,
  wsc_u16_cfg_if.sink   cfg_i,
  wsc_u16_out_if.source out_o
);

  res_t res;
  logic in_ready;

  wsc_u16_encoder u_encoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .in_ready_i (in_ready),
    .res_o      (res)
  );

  wsc_u16_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

  `WSC_ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni, out_o.valid && !out_o.ready, !in_i.ready)
  `WSC_ASSERT_SAME(a_load_nonempty, clk_i, rst_ni, res.load, res.count != 2'd0)
  `WSC_ASSERT_NEXT(a_block_start_silent, clk_i, rst_ni, in_i.valid && in_i.ready && !out_o.valid && (in_i.operation == OP_BLOCK_START), !out_o.valid)

endmodule
